[rtl/core/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants of the chunked body decoder
// Holds the parse phase codes, the byte codes and the result item type.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_LEAD_CR = 4'd1,
        PH_DIGITS  = 4'd2,
        PH_REST    = 4'd3,
        PH_REST_CR = 4'd4,
        PH_DATA    = 4'd5,
        PH_TRAIL0  = 4'd6,
        PH_TRAIL1  = 4'd7,
        PH_DONE    = 4'd8
    } t_phase;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       finished;
    } t_result;

    // Hex digit decode: bit 4 flags a digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[rtl/core/hcbd_step.sv]
// ----------------------------------------------------------------------------
// hcbd_step: next-state logic of the chunked body decoder
// Works out the next phase, the next count and the result item for one byte.
// ----------------------------------------------------------------------------
module hcbd_step #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  hcbd_pkg::t_phase        i_phase,
    input  logic [SIZE_BITS-1:0]    i_count,
    input  logic [7:0]              i_body_byte,
    input  logic                    i_body_end,
    output hcbd_pkg::t_phase        o_phase,
    output logic [SIZE_BITS-1:0]    o_count,
    output hcbd_pkg::t_result       o_res
);

    hcbd_pkg::t_phase     pe;
    hcbd_pkg::t_phase     ph;
    logic [SIZE_BITS-1:0] cnt;
    logic [SIZE_BITS-1:0] cnt_dec;
    logic [SIZE_BITS-1:0] cnt_add;
    logic [4:0]           hv;
    logic                 handled;
    logic                 is_cr;
    logic                 is_lf;

    assign hv    = hcbd_pkg::hex_val(i_body_byte);
    assign is_cr = (i_body_byte == hcbd_pkg::CH_CR);
    assign is_lf = (i_body_byte == hcbd_pkg::CH_LF);

    // Saturate once any of the top four bits is set.
    assign cnt_add = (i_count[SIZE_BITS-1 -: 4] != 4'd0) ? {SIZE_BITS{1'b1}}
                   : {i_count[SIZE_BITS-5:0], hv[3:0]};
    assign cnt_dec = (i_count != '0) ? i_count - SIZE_BITS'(1) : i_count;

    always_comb begin
        pe      = i_phase;
        ph      = i_phase;
        cnt     = i_count;
        handled = 1'b0;
        o_res   = '0;

        unique case (i_phase)
            hcbd_pkg::PH_TRAIL1: begin
                if (is_lf) begin
                    ph      = hcbd_pkg::PH_LEAD;
                    handled = 1'b1;
                end else begin
                    pe = hcbd_pkg::PH_LEAD;
                end
            end
            hcbd_pkg::PH_TRAIL0: begin
                if (is_cr) begin
                    ph      = hcbd_pkg::PH_TRAIL1;
                    handled = 1'b1;
                end else begin
                    pe = hcbd_pkg::PH_LEAD;
                end
            end
            hcbd_pkg::PH_LEAD, hcbd_pkg::PH_LEAD_CR, hcbd_pkg::PH_DIGITS,
            hcbd_pkg::PH_REST, hcbd_pkg::PH_REST_CR, hcbd_pkg::PH_DATA,
            hcbd_pkg::PH_DONE: begin
                pe = i_phase;
            end
            default: begin
                pe = hcbd_pkg::PH_LEAD;
            end
        endcase

        if (!handled) begin
            unique case (pe)
                hcbd_pkg::PH_LEAD, hcbd_pkg::PH_LEAD_CR: begin
                    if (pe == hcbd_pkg::PH_LEAD_CR && is_lf) begin
                        // empty size line ends the body
                        cnt            = '0;
                        o_res.finished = 1'b1;
                        ph             = hcbd_pkg::PH_DONE;
                    end else if (is_cr) begin
                        ph = hcbd_pkg::PH_LEAD_CR;
                    end else if (i_body_byte == hcbd_pkg::CH_SP ||
                                 i_body_byte == hcbd_pkg::CH_TAB) begin
                        ph = hcbd_pkg::PH_LEAD;
                    end else if (hv[4]) begin
                        cnt = SIZE_BITS'(hv[3:0]);
                        ph  = hcbd_pkg::PH_DIGITS;
                    end else begin
                        cnt = '0;
                        ph  = hcbd_pkg::PH_REST;
                    end
                end
                hcbd_pkg::PH_REST, hcbd_pkg::PH_REST_CR: begin
                    if (pe == hcbd_pkg::PH_REST_CR && is_lf) begin
                        if (i_count == '0) begin
                            o_res.finished = 1'b1;
                            ph             = hcbd_pkg::PH_DONE;
                        end else begin
                            ph = hcbd_pkg::PH_DATA;
                        end
                    end else begin
                        ph = is_cr ? hcbd_pkg::PH_REST_CR : hcbd_pkg::PH_REST;
                    end
                end
                hcbd_pkg::PH_DIGITS: begin
                    if (hv[4]) begin
                        cnt = cnt_add;
                        ph  = hcbd_pkg::PH_DIGITS;
                    end else begin
                        ph = is_cr ? hcbd_pkg::PH_REST_CR : hcbd_pkg::PH_REST;
                    end
                end
                hcbd_pkg::PH_DATA: begin
                    o_res.payload_valid = 1'b1;
                    o_res.payload_byte  = i_body_byte;
                    cnt                 = cnt_dec;
                    ph = (cnt_dec == '0) ? hcbd_pkg::PH_TRAIL0 : hcbd_pkg::PH_DATA;
                end
                default: begin
                    ph = hcbd_pkg::PH_DONE;
                end
            endcase
        end

        // body end: clear the phase and the count for the next body
        if (i_body_end) begin
            ph  = hcbd_pkg::PH_LEAD;
            cnt = '0;
        end

        o_phase = ph;
        o_count = cnt;
    end

endmodule

[rtl/core/hcbd_out_reg.sv]
// ----------------------------------------------------------------------------
// hcbd_out_reg: result register of the chunked body decoder
// Holds one result item and frees itself whenever the item is taken.
// ----------------------------------------------------------------------------
module hcbd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hcbd_pkg::t_result i_res,
    input  logic              i_take,
    output logic              o_valid,
    output hcbd_pkg::t_result o_res,
    output logic              o_free
);

    logic              r_valid;
    hcbd_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    // free when empty or when the waiting item leaves this cycle
    assign o_free  = !r_valid || i_take;

endmodule

[rtl/core/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: streaming decoder for a chunked HTTP body
// Parses hex size lines, passes chunk data bytes through and flags the end.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  in      | i_in_valid / o_in_ready   | i_body_byte, i_body_end
//  out     | o_out_valid / i_out_ready | o_payload_valid, o_payload_byte,
//          |                           | o_finished
//
//  One item a cycle; each accepted byte gives exactly one result item, ready
//  in the result register in the cycle after acceptance. The parse state
//  (phase and chunk count) and the result register both load on acceptance.
//  Input is taken whenever the result register is empty or being emptied, so
//  the rate falls only while the output side stalls. Reset is synchronous and
//  puts the parser at the start of a size line with a zero count.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_body_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_payload_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_finished
);

    hcbd_pkg::t_phase     r_phase;
    hcbd_pkg::t_phase     n_phase;
    logic [SIZE_BITS-1:0] r_count;
    logic [SIZE_BITS-1:0] n_count;
    hcbd_pkg::t_result    step_res;
    hcbd_pkg::t_result    out_res;
    logic                 load;

    assign load = i_in_valid && o_in_ready;

    // next phase, next count and result item for the byte on offer
    hcbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_phase     (r_phase),
        .i_count     (r_count),
        .i_body_byte (i_body_byte),
        .i_body_end  (i_body_end),
        .o_phase     (n_phase),
        .o_count     (n_count),
        .o_res       (step_res)
    );

    // parse state: advance only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hcbd_pkg::PH_LEAD;
            r_count <= '0;
        end else if (load) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // result register: hold the item until the output side takes it
    hcbd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (step_res),
        .i_take  (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_free  (o_in_ready)
    );

    assign o_payload_valid = out_res.payload_valid;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_finished      = out_res.finished;

    // a stalled result must block new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result stalled");

    // a body end clears the parser
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_body_end) |=> (r_phase == hcbd_pkg::PH_LEAD && r_count == '0))
        else $error("state not cleared after body end");

    // a result is never both data and the end mark
    a_fin_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_finished && o_payload_valid))
        else $error("finished result carries payload");

    // data leaves only from the data phase
    a_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_phase != hcbd_pkg::PH_DATA) |=> !o_payload_valid)
        else $error("payload outside data phase");

endmodule
